// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/scs_pkg.sv -----
// ---------------------------------------------------------------------------
// SQL comment stripper package
// Character codes, result beat type, queue sizing and status struct.
// ---------------------------------------------------------------------------
package scs_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Most results one character can cause
  localparam int MAX_RES = 2;
  localparam int PUSH_W  = $clog2(MAX_RES + 1);

  // Result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_HELD_SLASH = 3'd1,
    MODE_HELD_DASH  = 3'd2,
    MODE_BLOCK      = 3'd3,
    MODE_BLOCK_STAR = 3'd4,
    MODE_BLOCK_SLSH = 3'd5,
    MODE_LINE       = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       valid;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               has_room;
  } q_stat_t;

endpackage

// ----- rtl/sql_comment_stripper.sv -----
// ---------------------------------------------------------------------------
// SQL comment stripper
// Drops block and line comments from a query byte stream.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_stall    | in_char, in_last
//   out     | output    | out_beat_valid / out_stall | out_char, out_valid, out_last
//
// One character is taken per cycle while in_stall is low; its beats, if any, enter the registered result queue.
// With the output free the four-entry queue gains an entry per two-beat
// character and loses one per character that yields nothing; input stalls
// whenever three or more entries are held (fewer than two free).
// Synchronous active-low reset returns the scanner to plain text, queue empty.
// Output stall backs up through the queue to in_stall; no beat is dropped.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sql_comment_stripper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_beat_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_valid,
  output logic       out_last
);
  import scs_pkg::*;

  logic              in_acc;
  logic              out_acc;
  logic [PUSH_W-1:0] scan_push;
  logic [PUSH_W-1:0] q_push;
  res_t              scan_r0, scan_r1;
  res_t              q_head;
  q_stat_t           q_stat;

  assign in_stall = !q_stat.has_room;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_beat_valid && !out_stall;
  assign q_push   = in_acc ? scan_push : '0;

  scs_scanner u_scanner (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .chr    (in_char),
    .last   (in_last),
    .push_n (scan_push),
    .res0   (scan_r0),
    .res1   (scan_r1)
  );

  scs_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (q_push),
    .res0     (scan_r0),
    .res1     (scan_r1),
    .pop      (out_acc),
    .head     (q_head),
    .nonempty (out_beat_valid),
    .stat     (q_stat)
  );

  assign out_char  = q_head.chr;
  assign out_valid = q_head.valid;
  assign out_last  = q_head.last;

  `ASSERT_IMPL(a_bare_is_end, clk, rst_n, out_beat_valid && !out_valid,
               out_last && out_char == 8'h00, "bare beat without end mark")
  `ASSERT_NEXT(a_last_gives_beat, clk, rst_n, in_acc && in_last, out_beat_valid,
               "end of query produced no beat")
  `ASSERT_IMPL(a_no_overflow, clk, rst_n, 1'b1, q_stat.count <= Q_CNT_W'(Q_DEPTH),
               "result queue overflow")

endmodule

// ----- rtl/scs_scanner.sv -----
// ---------------------------------------------------------------------------
// Comment scanner
// Holds the scan mode and turns each character into zero to two result beats.
// ---------------------------------------------------------------------------
module scs_scanner (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [7:0]                   chr,
  input  logic                         last,
  output logic [scs_pkg::PUSH_W-1:0]   push_n,
  output scs_pkg::res_t                res0,
  output scs_pkg::res_t                res1
);
  import scs_pkg::*;

  mode_t mode_r, mode_nxt;
  mode_t m_pre;
  mode_t nc_mode;

  logic       nc_en;
  logic       a_v, b_v, c_v;
  logic [7:0] a_c, c_c;
  logic [1:0] cnt;
  res_t       r0, r1;

  // Plain character in normal text
  always_comb begin
    case (chr)
      CH_SLASH: nc_mode = MODE_HELD_SLASH;
      CH_DASH:  nc_mode = MODE_HELD_DASH;
      CH_HASH:  nc_mode = MODE_LINE;
      default:  nc_mode = MODE_NORMAL;
    endcase
  end

  always_comb begin
    nc_en = 1'b0;
    a_v   = 1'b0;
    a_c   = CH_SLASH;
    m_pre = MODE_NORMAL;
    case (mode_r)
      MODE_HELD_SLASH: begin
        if (chr == CH_STAR) begin
          m_pre = MODE_BLOCK;
        end else begin
          a_v   = 1'b1;
          a_c   = CH_SLASH;
          nc_en = 1'b1;
        end
      end
      MODE_HELD_DASH: begin
        if (chr == CH_DASH) begin
          m_pre = MODE_LINE;
        end else begin
          a_v   = 1'b1;
          a_c   = CH_DASH;
          nc_en = 1'b1;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR, MODE_BLOCK_SLSH: begin
        if (mode_r == MODE_BLOCK_STAR && chr == CH_SLASH) begin
          m_pre = MODE_NORMAL;
        end else if (mode_r == MODE_BLOCK_SLSH && chr == CH_STAR) begin
          // slash-star inside a comment is eaten whole
          m_pre = MODE_BLOCK;
        end else if (chr == CH_SLASH) begin
          m_pre = MODE_BLOCK_SLSH;
        end else if (chr == CH_STAR) begin
          m_pre = MODE_BLOCK_STAR;
        end else begin
          m_pre = MODE_BLOCK;
        end
      end
      MODE_LINE: begin
        m_pre = (chr == CH_NL) ? MODE_NORMAL : MODE_LINE;
      end
      default: begin
        nc_en = 1'b1;
      end
    endcase
    if (nc_en) begin
      m_pre = nc_mode;
    end
  end

  // Emit candidates in order: flushed held char, plain char, end-of-query flush
  assign b_v = nc_en && (nc_mode == MODE_NORMAL);
  assign c_v = last && ((m_pre == MODE_HELD_SLASH) || (m_pre == MODE_HELD_DASH));
  assign c_c = (m_pre == MODE_HELD_SLASH) ? CH_SLASH : CH_DASH;
  assign cnt = 2'({1'b0, a_v}) + 2'({1'b0, b_v}) + 2'({1'b0, c_v});

  always_comb begin
    r0 = '0;
    r1 = '0;
    if (a_v) begin
      r0 = '{chr: a_c, valid: 1'b1, last: 1'b0};
      if (b_v) begin
        r1 = '{chr: chr, valid: 1'b1, last: 1'b0};
      end else begin
        r1 = '{chr: c_c, valid: 1'b1, last: 1'b0};
      end
    end else if (b_v) begin
      r0 = '{chr: chr, valid: 1'b1, last: 1'b0};
      r1 = '{chr: c_c, valid: 1'b1, last: 1'b0};
    end else if (c_v) begin
      r0 = '{chr: c_c, valid: 1'b1, last: 1'b0};
    end
    // Mark the final beat of the query; bare marker when nothing else goes out
    if (last) begin
      if (cnt == 2'd2) begin
        r1.last = 1'b1;
      end else begin
        r0.last = 1'b1;
      end
    end
  end

  assign res0     = r0;
  assign res1     = r1;
  assign push_n   = (last && cnt == 2'd0) ? PUSH_W'(1) : PUSH_W'(cnt);
  assign mode_nxt = last ? MODE_NORMAL : m_pre;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// ----- rtl/scs_outq.sv -----
// ---------------------------------------------------------------------------
// Result queue
// Small circular queue taking up to two beats a cycle and giving one.
// ---------------------------------------------------------------------------
module scs_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [scs_pkg::PUSH_W-1:0]   push_n,
  input  scs_pkg::res_t                res0,
  input  scs_pkg::res_t                res1,
  input  logic                         pop,
  output scs_pkg::res_t                head,
  output logic                         nonempty,
  output scs_pkg::q_stat_t             stat
);
  import scs_pkg::*;

  res_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
  assign count_nxt  = count_r + Q_CNT_W'(push_n) - Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != '0) begin
      mem[wr_ptr_r] <= res0;
    end
    if (push_n > PUSH_W'(1)) begin
      mem[wr_ptr_r + Q_PTR_W'(1)] <= res1;
    end
  end

  assign head          = mem[rd_ptr_r];
  assign nonempty      = (count_r != '0);
  assign stat.count    = count_r;
  // Room for a worst-case character
  assign stat.has_room = (count_r <= Q_CNT_W'(Q_DEPTH - MAX_RES));

endmodule

// ----- bench/sql_comment_stripper_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// SQL comment stripper testbench
// Feeds query bytes through the stripper under random idling on both sides and
// checks every result beat, field by field, against a local scanner model or
// a typed row's table result. A short directed table covers extremes and comment
// corner cases; generated queries with random content and broken endings follow.
// ---------------------------------------------------------------------------
module sql_comment_stripper_test;
  import scs_pkg::*;

  localparam int N_DIR      = 25;
  localparam int N_RANDOM   = 1300;
  localparam int CALM_AFTER = 1150;
  localparam int HOLD_LEN   = 80;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    res_t       want;
  } dir_row_t;

  localparam res_t NO_RES  = '{8'h00, 1'b0, 1'b0};
  localparam res_t END_RES = '{8'h00, 1'b0, 1'b1};

  // Directed rows; typed rows carry the result that is plain on sight
  dir_row_t dir_tab [N_DIR] = '{
    '{8'h41,    1'b0, 1'b1, '{8'h41, 1'b1, 1'b0}},
    '{8'h00,    1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{8'hFF,    1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{CH_SLASH, 1'b0, 1'b0, NO_RES},
    '{CH_STAR,  1'b0, 1'b0, NO_RES},
    '{CH_SLASH, 1'b0, 1'b0, NO_RES},
    '{CH_STAR,  1'b0, 1'b0, NO_RES},
    '{CH_SLASH, 1'b0, 1'b0, NO_RES},   // star was eaten by slash-star: stays open
    '{CH_STAR,  1'b0, 1'b0, NO_RES},
    '{CH_STAR,  1'b0, 1'b0, NO_RES},
    '{CH_SLASH, 1'b0, 1'b0, NO_RES},
    '{CH_DASH,  1'b0, 1'b0, NO_RES},
    '{8'h78,    1'b0, 1'b0, NO_RES},   // held dash plus char: two beats
    '{CH_DASH,  1'b0, 1'b0, NO_RES},
    '{CH_DASH,  1'b0, 1'b0, NO_RES},
    '{8'h71,    1'b0, 1'b0, NO_RES},
    '{CH_NL,    1'b0, 1'b0, NO_RES},
    '{CH_HASH,  1'b0, 1'b0, NO_RES},
    '{CH_SLASH, 1'b1, 1'b1, END_RES},
    '{CH_SLASH, 1'b1, 1'b1, '{CH_SLASH, 1'b1, 1'b1}},
    '{CH_DASH,  1'b0, 1'b0, NO_RES},
    '{CH_SLASH, 1'b1, 1'b0, NO_RES},
    '{CH_SLASH, 1'b0, 1'b0, NO_RES},
    '{CH_STAR,  1'b1, 1'b1, END_RES},
    '{CH_DASH,  1'b1, 1'b1, '{CH_DASH, 1'b1, 1'b1}}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char;
  logic       in_last;
  logic       out_beat_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       out_valid;
  logic       out_last;

  mode_t      scan_st;
  res_t       step_res [2];
  int         step_n;
  res_t       kept_q [$];
  logic [7:0] query_q [$];
  int         err_cnt;
  int         n_sent;
  int         beats_seen;
  int         idle_cycles;
  bit         calm;
  bit         rx_hold;
  bit         hold_done;

  sql_comment_stripper u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char        (in_char),
    .in_last        (in_last),
    .out_beat_valid (out_beat_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_valid      (out_valid),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---- scanner model ----

  function automatic void add_res(input logic [7:0] c, input logic v);
    step_res[step_n] = '{c, v, 1'b0};
    step_n++;
  endfunction

  function automatic mode_t plain_char(input logic [7:0] c);
    if (c == CH_SLASH) return MODE_HELD_SLASH;
    if (c == CH_DASH) return MODE_HELD_DASH;
    if (c == CH_HASH) return MODE_LINE;
    add_res(c, 1'b1);
    return MODE_NORMAL;
  endfunction

  function automatic mode_t comment_char(input logic [7:0] c);
    if (c == CH_SLASH) return MODE_BLOCK_SLSH;
    if (c == CH_STAR) return MODE_BLOCK_STAR;
    return MODE_BLOCK;
  endfunction

  function automatic void strip_char(input logic [7:0] c, input logic last);
    mode_t nxt;
    step_n = 0;
    case (scan_st)
      MODE_HELD_SLASH: begin
        if (c == CH_STAR) begin
          nxt = MODE_BLOCK;
        end else begin
          add_res(CH_SLASH, 1'b1);
          nxt = plain_char(c);
        end
      end
      MODE_HELD_DASH: begin
        if (c == CH_DASH) begin
          nxt = MODE_LINE;
        end else begin
          add_res(CH_DASH, 1'b1);
          nxt = plain_char(c);
        end
      end
      MODE_BLOCK:      nxt = comment_char(c);
      MODE_BLOCK_STAR: nxt = (c == CH_SLASH) ? MODE_NORMAL : comment_char(c);
      MODE_BLOCK_SLSH: nxt = (c == CH_STAR) ? MODE_BLOCK : comment_char(c);
      MODE_LINE:       nxt = (c == CH_NL) ? MODE_NORMAL : MODE_LINE;
      default:         nxt = plain_char(c);
    endcase
    if (last) begin
      // flush a held marker, drop an open comment
      if (nxt == MODE_HELD_SLASH) begin
        add_res(CH_SLASH, 1'b1);
      end else if (nxt == MODE_HELD_DASH) begin
        add_res(CH_DASH, 1'b1);
      end
      if (step_n == 0) add_res(8'h00, 1'b0);
      step_res[step_n-1].last = 1'b1;
      nxt = MODE_NORMAL;
    end
    scan_st = nxt;
  endfunction

  // ---- stimulus ----

  function automatic logic [7:0] pick_marker();
    case ($urandom_range(0, 4))
      0:       return CH_SLASH;
      1:       return CH_STAR;
      2:       return CH_HASH;
      3:       return CH_DASH;
      default: return CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] pick_body();
    if ($urandom_range(0, 2) == 0) return pick_marker();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void build_query();
    int n_tok;
    int len;
    query_q.delete();
    n_tok = $urandom_range(1, 8);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          len = $urandom_range(1, 6);
          repeat (len) query_q.push_back(8'($urandom_range(0, 255)));
        end
        2: begin
          query_q.push_back(CH_SLASH);
          query_q.push_back(CH_STAR);
          len = $urandom_range(0, 5);
          repeat (len) query_q.push_back(pick_body());
          query_q.push_back(CH_STAR);
          query_q.push_back(CH_SLASH);
        end
        3: begin
          if ($urandom_range(0, 1) == 0) begin
            query_q.push_back(CH_HASH);
          end else begin
            query_q.push_back(CH_DASH);
            query_q.push_back(CH_DASH);
          end
          len = $urandom_range(0, 5);
          repeat (len) query_q.push_back(pick_body());
          query_q.push_back(CH_NL);
        end
        4: query_q.push_back(($urandom_range(0, 1) == 0) ? CH_SLASH : CH_DASH);
        default: begin
          len = $urandom_range(1, 4);
          repeat (len) query_q.push_back(pick_marker());
        end
      endcase
    end
    // break some queries off mid-token
    if ($urandom_range(0, 9) == 0 && query_q.size() > 1) begin
      len = $urandom_range(1, query_q.size() - 1);
      while (query_q.size() > len) void'(query_q.pop_back());
    end
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic last, input logic typed,
                           input res_t want);
    in_valid <= 1'b1;
    in_char  <= ch;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    strip_char(ch, last);
    if (typed) begin
      kept_q.push_back(want);
    end else begin
      for (int k = 0; k < step_n; k++) kept_q.push_back(step_res[k]);
    end
    n_sent++;
    if (!calm && !rx_hold && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic report_err(input string what);
    $display("mismatch @%0t: %s", $time, what);
    err_cnt++;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_char   <= 8'h00;
    in_last   <= 1'b0;
    scan_st   = MODE_NORMAL;
    err_cnt   = 0;
    n_sent    = 0;
    calm      = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      push_char(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
    end

    while (n_sent < N_DIR + N_RANDOM) begin
      build_query();
      foreach (query_q[i]) begin
        if (n_sent >= N_DIR + CALM_AFTER) calm = 1'b1;
        push_char(query_q[i], i == query_q.size() - 1, 1'b0, NO_RES);
      end
    end
    in_valid <= 1'b0;

    while (kept_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** sql_comment_stripper: PASSED **");
    end else begin
      $display("** sql_comment_stripper: FAILED **");
    end
    $finish;
  end

  // ---- receiver ----

  initial begin
    out_stall <= 1'b0;
    rx_hold   = 1'b0;
    hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!calm && !hold_done && beats_seen >= 200) begin
        // hold off long enough for the queue to fill and back up the input
        hold_done = 1'b1;
        rx_hold   = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
        rx_hold   = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---- result check and watchdog ----

  initial begin
    beats_seen  = 0;
    idle_cycles = 0;
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_beat_valid && !out_stall) begin
      beats_seen++;
      if (kept_q.size() == 0) begin
        report_err($sformatf("unexpected beat char %02h valid %b last %b",
                             out_char, out_valid, out_last));
      end else begin
        want = kept_q.pop_front();
        if (out_char !== want.chr)
          report_err($sformatf("out_char %02h, want %02h", out_char, want.chr));
        if (out_valid !== want.valid)
          report_err($sformatf("out_valid %b, want %b", out_valid, want.valid));
        if (out_last !== want.last)
          report_err($sformatf("out_last %b, want %b", out_last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_beat_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("** sql_comment_stripper: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
